@@ rtl/pbs_pkg.sv @@
// Shared types, widths and codes for the packet burst splitter.
package pbs_pkg;

  // Store geometry
  localparam int MAX_UNIQUE = 16;
  localparam int CNT_W      = $clog2(MAX_UNIQUE + 1);

  // Field widths
  localparam int OP_W      = 1;
  localparam int TIME_W    = 63;
  localparam int LEN_W     = 17;
  localparam int LIMIT_W   = 48;
  localparam int UL_W      = 5;
  localparam int PKT_CNT_W = 16;
  localparam int CMP_W     = (CNT_W > UL_W) ? CNT_W : UL_W;

  localparam logic [PKT_CNT_W-1:0] PKT_CNT_MAX = {PKT_CNT_W{1'b1}};

  // Op codes
  localparam logic [OP_W-1:0] OP_PACKET = 1'b0;
  localparam logic [OP_W-1:0] OP_FLUSH  = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LIMIT_W;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_GAP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_SPAN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNIQUE_LIM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_SHORT = 2'd3;

  // Control handed from the burst logic to the length store chain
  typedef struct packed {
    logic             shift;       // push len into cell 0, rest move up one
    logic [LEN_W-1:0] len;         // length to compare and to push
    logic [CNT_W-1:0] live_count;  // cells below this index hold live entries
  } pbs_chain_ctl_t;

endpackage

@@ rtl/pbs_if.sv @@
// Valid/ready channel interfaces for packet beats and result beats.
interface pbs_in_if;
  import pbs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [TIME_W-1:0]        arrival_time;
  logic signed [LEN_W-1:0]  signed_length;

  modport source (output valid, op, arrival_time, signed_length, input ready);
  modport sink   (input valid, op, arrival_time, signed_length, output ready);
endinterface

interface pbs_out_if;
  import pbs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  burst_closed;
  logic                  closed_is_long;
  logic [PKT_CNT_W-1:0]  closed_packet_count;

  modport source (output valid, burst_closed, closed_is_long, closed_packet_count,
                  input ready);
  modport sink   (input valid, burst_closed, closed_is_long, closed_packet_count,
                  output ready);
endinterface

@@ rtl/pbs_cell.sv @@
// One cell of the unique-length store: holds a length, matches it, passes it on.
module pbs_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [pbs_pkg::LEN_W-1:0] din,
  input  logic [pbs_pkg::LEN_W-1:0] probe,
  input  logic                      live,
  input  logic                      hit_in,
  output logic [pbs_pkg::LEN_W-1:0] dout,
  output logic                      hit_out
);
  import pbs_pkg::*;

  logic [LEN_W-1:0] len_r;

  // Take the neighbor's value when the chain shifts
  always_ff @(posedge clk) begin
    if (shift) begin
      len_r <= din;
    end
  end

  assign dout    = len_r;
  // Match ripples down the row
  assign hit_out = hit_in | (live & (len_r == probe));
endmodule

@@ rtl/pbs_cell_chain.sv @@
// Row of length cells: parallel match of a length, push-in at the head.
module pbs_cell_chain (
  input  logic                    clk,
  input  pbs_pkg::pbs_chain_ctl_t ctl,
  output logic                    known
);
  import pbs_pkg::*;

  logic [LEN_W-1:0] data [MAX_UNIQUE+1];
  logic             hit  [MAX_UNIQUE+1];

  assign data[0] = ctl.len;
  assign hit[0]  = 1'b0;

  for (genvar i = 0; i < MAX_UNIQUE; i++) begin : g_cell
    pbs_cell u_cell (
      .clk     (clk),
      .shift   (ctl.shift),
      .din     (data[i]),
      .probe   (ctl.len),
      .live    (CNT_W'(i) < ctl.live_count),
      .hit_in  (hit[i]),
      .dout    (data[i+1]),
      .hit_out (hit[i+1])
    );
  end

  assign known = hit[MAX_UNIQUE];
endmodule

@@ rtl/packet_burst_long_short_splitter.sv @@
// Top level of the packet burst splitter: burst state, limits and result register.
//
// Cuts a time-ordered packet stream into bursts. Every accepted beat, packet or
// end-of-stream flush, yields exactly one registered result beat: whether a burst
// was closed, whether it was long, and its saturated packet count. The burst state,
// the two 63-bit time compares and the match across the sixteen-cell length store
// all settle within the cycle of the accepting edge. A single result register holds
// the outcome; the next beat enters in the cycle the sink takes the pending result,
// so one beat is taken per clock cycle while the sink keeps up. Limits are written
// through the cfg_ port, by the user only while idle; the block does not enforce it.
module packet_burst_long_short_splitter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  pbs_in_if.sink                         in_ch,
  pbs_out_if.source                      out_ch
);
  import pbs_pkg::*;

  // Configuration registers
  logic [LIMIT_W-1:0] inner_gap_r, outer_span_r;
  logic [UL_W-1:0]    unique_limit_r;
  logic               long_short_r;

  // Burst state
  logic                 burst_open_r, burst_open_nxt;
  logic [TIME_W-1:0]    first_time_r, first_time_nxt;
  logic [TIME_W-1:0]    last_time_r, last_time_nxt;
  logic [CNT_W-1:0]     unique_count_r, unique_count_nxt;
  logic [PKT_CNT_W-1:0] packet_count_r, packet_count_nxt;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 res_closed_r, res_closed_nxt;
  logic                 res_long_r, res_long_nxt;
  logic [PKT_CNT_W-1:0] res_count_r, res_count_nxt;

  logic                 in_fire;
  logic                 is_flush;
  logic [TIME_W:0]      gap_diff, span_diff;
  logic                 gap_split, span_split, uniq_split;
  logic [CMP_W-1:0]     lim_ext;
  logic                 known;
  logic                 closed, is_long;
  logic [CNT_W-1:0]     count_after;
  logic                 known_after;
  pbs_chain_ctl_t       chain_ctl;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign is_flush = (in_ch.op == OP_FLUSH);

  // Config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_gap_r    <= '0;
      outer_span_r   <= '0;
      unique_limit_r <= UL_W'(MAX_UNIQUE);
      long_short_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INNER_GAP:  inner_gap_r    <= cfg_wdata[LIMIT_W-1:0];
        REG_OUTER_SPAN: outer_span_r   <= cfg_wdata[LIMIT_W-1:0];
        REG_UNIQUE_LIM: unique_limit_r <= cfg_wdata[UL_W-1:0];
        REG_LONG_SHORT: long_short_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Gap and span; time going backwards counts as zero
  assign gap_diff   = {1'b0, in_ch.arrival_time} - {1'b0, last_time_r};
  assign span_diff  = {1'b0, in_ch.arrival_time} - {1'b0, first_time_r};
  assign gap_split  = !gap_diff[TIME_W] &&
                      (gap_diff[TIME_W-1:0] > TIME_W'(inner_gap_r));
  assign span_split = !span_diff[TIME_W] &&
                      (span_diff[TIME_W-1:0] > TIME_W'(outer_span_r));

  // Uniqueness rule with the limit clamped to the store size
  assign lim_ext    = (CMP_W'(unique_limit_r) > CMP_W'(MAX_UNIQUE)) ?
                      CMP_W'(MAX_UNIQUE) : CMP_W'(unique_limit_r);
  assign uniq_split = (lim_ext != '0) && (CMP_W'(unique_count_r) == lim_ext) && !known;

  // Close decision
  always_comb begin
    closed  = 1'b0;
    is_long = 1'b0;
    if (burst_open_r) begin
      if (is_flush) begin
        closed = 1'b1;
      end else if (gap_split) begin
        closed = 1'b1;
      end else if (span_split || uniq_split) begin
        closed  = 1'b1;
        is_long = long_short_r;
      end
    end
  end

  // Store view after a possible close
  assign count_after = closed ? '0 : unique_count_r;
  assign known_after = known && !closed;

  assign chain_ctl.len        = in_ch.signed_length;
  assign chain_ctl.live_count = unique_count_r;
  assign chain_ctl.shift      = in_fire && !is_flush && !known_after &&
                                (count_after < CNT_W'(MAX_UNIQUE));

  pbs_cell_chain u_chain (
    .clk   (clk),
    .ctl   (chain_ctl),
    .known (known)
  );

  // Next burst state
  always_comb begin
    burst_open_nxt   = burst_open_r;
    first_time_nxt   = first_time_r;
    last_time_nxt    = last_time_r;
    unique_count_nxt = unique_count_r;
    packet_count_nxt = packet_count_r;
    if (in_fire) begin
      if (is_flush) begin
        if (burst_open_r) begin
          burst_open_nxt   = 1'b0;
          unique_count_nxt = '0;
          packet_count_nxt = '0;
        end
      end else begin
        burst_open_nxt = 1'b1;
        if (!burst_open_r || closed) begin
          first_time_nxt   = in_ch.arrival_time;
          packet_count_nxt = PKT_CNT_W'(1);
        end else if (packet_count_r != PKT_CNT_MAX) begin
          packet_count_nxt = packet_count_r + PKT_CNT_W'(1);
        end
        last_time_nxt    = in_ch.arrival_time;
        unique_count_nxt = count_after + CNT_W'(chain_ctl.shift);
      end
    end
  end

  // Result register; a new beat may enter while the sink takes the old one
  assign in_ch.ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    res_closed_nxt = res_closed_r;
    res_long_nxt   = res_long_r;
    res_count_nxt  = res_count_r;
    if (in_fire) begin
      out_valid_nxt  = 1'b1;
      res_closed_nxt = closed;
      res_long_nxt   = closed && is_long;
      res_count_nxt  = closed ? packet_count_r : '0;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_open_r   <= 1'b0;
      first_time_r   <= '0;
      last_time_r    <= '0;
      unique_count_r <= '0;
      packet_count_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      burst_open_r   <= burst_open_nxt;
      first_time_r   <= first_time_nxt;
      last_time_r    <= last_time_nxt;
      unique_count_r <= unique_count_nxt;
      packet_count_r <= packet_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_closed_r <= res_closed_nxt;
    res_long_r   <= res_long_nxt;
    res_count_r  <= res_count_nxt;
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.burst_closed        = res_closed_r;
  assign out_ch.closed_is_long      = res_long_r;
  assign out_ch.closed_packet_count = res_count_r;

  // Checks
  a_long_needs_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_long_r |-> res_closed_r)
    else $error("long flag without a closed burst");

  a_closed_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_closed_r |-> res_count_r != '0)
    else $error("closed burst with zero packets");

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    unique_count_r <= CNT_W'(MAX_UNIQUE))
    else $error("unique count beyond store size");

  a_flush_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_flush |=> !burst_open_r && unique_count_r == '0)
    else $error("flush left a burst open");

  a_packet_opens: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !is_flush |=> burst_open_r && packet_count_r != '0 &&
                             unique_count_r != '0)
    else $error("packet did not open or join a burst");
endmodule
